[design/assert_macros.svh]
// Assertion macros for the box blur design files, used by the top level.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BB3_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("box blur assertion failed");

// Next-cycle implication, checked outside reset.
`define BB3_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("box blur assertion failed");

`endif

[design/bb3_pkg.sv]
// Shared types and constants of the 3x3 box blur stream core.
// Depends on nothing; imported by the configuration, control, mean and top-level modules.
package bb3_pkg;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int FW_W       = 6;
    localparam int FH_W       = 12;
    localparam int FIELD_W    = 8;

    // Register indexes, taken from the word address bit of paddr.
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    localparam logic [FW_W-1:0] FW_RESET = 6'd5;
    localparam logic [FH_W-1:0] FH_RESET = 12'd5;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_ACC,
        S_MUL
    } t_state;

    // Sequencer to datapath controls.
    typedef struct packed {
        logic clr;
        logic en;
        logic load;
        logic interior;
        logic last;
        logic eof;
    } t_acc_ctl;

endpackage

[design/bb3_line_store.sv]
// Line store of original pixels: one write port and one registered read port.
// Depends on nothing; instantiated by the top level.
module bb3_line_store #(
    parameter int DEPTH  = 96,
    parameter int DATA_W = 8
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [DATA_W-1:0]        i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [DATA_W-1:0]        o_rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[design/bb3_cfg.sv]
// APB register file holding frame width and height, with clamped limits.
// Depends on bb3_pkg.
module bb3_cfg #(
    parameter int MAX_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bb3_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [bb3_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [bb3_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,
    output logic [$clog2(MAX_WIDTH)-1:0]        o_wlast,
    output logic [bb3_pkg::FH_W-1:0]            o_hlast,
    output logic                                o_restart
);
    import bb3_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);

    logic [FW_W-1:0] r_frame_width;
    logic [FH_W-1:0] r_frame_height;
    logic            wr_stb;
    logic            reg_idx;
    logic [FW_W-1:0] wlast_full;

    assign pready  = 1'b1;
    assign wr_stb  = psel & penable & pwrite;
    assign reg_idx = paddr[APB_ADDR_W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FW_RESET;
            r_frame_height <= FH_RESET;
        end else if (wr_stb) begin
            case (reg_idx)
                REG_FRAME_WIDTH:  r_frame_width  <= pwdata[FW_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= pwdata[FH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_FRAME_WIDTH:  prdata = APB_DATA_W'(r_frame_width);
            REG_FRAME_HEIGHT: prdata = APB_DATA_W'(r_frame_height);
            default:          prdata = '0;
        endcase
    end

    // Out-of-range widths are clamped to 3..MAX_WIDTH; heights are only clamped from below, to 3.
    always_comb begin
        if (r_frame_width < FW_W'(3)) begin
            wlast_full = FW_W'(2);
        end else if (r_frame_width > FW_W'(MAX_WIDTH)) begin
            wlast_full = FW_W'(MAX_WIDTH - 1);
        end else begin
            wlast_full = r_frame_width - FW_W'(1);
        end
    end

    assign o_wlast   = wlast_full[COL_W-1:0];
    assign o_hlast   = (r_frame_height < FH_W'(3)) ? FH_W'(2) : r_frame_height - FH_W'(1);
    assign o_restart = wr_stb;

endmodule

[design/bb3_ctrl.sv]
// Frame position counters and the read sequencer that walks the line store.
// Depends on bb3_pkg; drives the line store ports and the mean datapath.
module bb3_ctrl #(
    parameter int MAX_WIDTH = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_valid,
    output logic                                  o_s_ready,
    input  logic [$clog2(MAX_WIDTH)-1:0]          i_wlast,
    input  logic [bb3_pkg::FH_W-1:0]              i_hlast,
    input  logic                                  i_restart,
    input  logic                                  i_out_free,
    output logic                                  o_wr_en,
    output logic [$clog2(3*MAX_WIDTH)-1:0]        o_wr_addr,
    output logic                                  o_rd_en,
    output logic [$clog2(3*MAX_WIDTH)-1:0]        o_rd_addr,
    output bb3_pkg::t_acc_ctl                     o_acc
);
    import bb3_pkg::*;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ADDR_W = $clog2(3 * MAX_WIDTH);
    localparam logic [ADDR_W-1:0] SPAN1 = ADDR_W'(MAX_WIDTH);
    localparam logic [ADDR_W-1:0] SPAN2 = ADDR_W'(2 * MAX_WIDTH);

    function automatic logic [1:0] mod3_inc(input logic [1:0] m);
        return (m == 2'd2) ? 2'd0 : m + 2'd1;
    endfunction

    function automatic logic [1:0] mod3_dec(input logic [1:0] m);
        return (m == 2'd0) ? 2'd2 : m - 2'd1;
    endfunction

    function automatic logic [ADDR_W-1:0] row_base(input logic [1:0] m);
        logic [ADDR_W-1:0] b;
        case (m)
            2'd1:    b = SPAN1;
            2'd2:    b = SPAN2;
            default: b = '0;
        endcase
        return b;
    endfunction

    t_state           r_state, n_state;
    logic [COL_W-1:0] r_col, r_ocol;
    logic [FH_W-1:0]  r_row, r_orow;
    logic [1:0]       r_rmod, r_omod;
    logic             r_final;
    logic [1:0]       r_dr, r_dc;

    logic             accept, is_final, has_res, interior, last_tap, eof, last_res, load;
    logic [1:0]       rd_mod;
    logic [COL_W-1:0] rd_col;

    assign accept   = (r_state == S_IDLE) && i_s_valid;
    assign is_final = (r_row == i_hlast) && (r_col == i_wlast);
    assign has_res  = (r_row >= FH_W'(2)) || ((r_row == FH_W'(1)) && (r_col != '0));
    assign interior = (r_orow != '0) && (r_orow != i_hlast) &&
                      (r_ocol != '0) && (r_ocol != i_wlast);
    assign last_tap = !interior || ((r_dr == 2'd2) && (r_dc == 2'd2));
    assign eof      = r_final && (r_orow == i_hlast) && (r_ocol == i_wlast);
    assign last_res = !r_final || eof;
    assign load     = (r_state == S_MUL) && i_out_free;

    always_comb begin
        if (!interior) begin
            rd_mod = r_omod;
            rd_col = r_ocol;
        end else begin
            case (r_dr)
                2'd0:    rd_mod = mod3_dec(r_omod);
                2'd2:    rd_mod = mod3_inc(r_omod);
                default: rd_mod = r_omod;
            endcase
            rd_col = r_ocol + COL_W'(r_dc) - COL_W'(1);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (accept && has_res) n_state = S_READ;
            S_READ: if (last_tap) n_state = S_ACC;
            S_ACC:  n_state = S_MUL;
            S_MUL:  if (i_out_free) n_state = last_res ? S_IDLE : S_READ;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_s_ready      = (r_state == S_IDLE);
        o_wr_en        = accept;
        o_wr_addr      = row_base(r_rmod) + ADDR_W'(r_col);
        o_rd_en        = (r_state == S_READ);
        o_rd_addr      = row_base(rd_mod) + ADDR_W'(rd_col);
        o_acc.clr      = accept || load;
        o_acc.en       = ((r_state == S_READ) && !((r_dr == 2'd0) && (r_dc == 2'd0))) ||
                         (r_state == S_ACC);
        o_acc.load     = load;
        o_acc.interior = interior;
        o_acc.last     = last_res;
        o_acc.eof      = eof;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_col   <= '0;
            r_row   <= '0;
            r_rmod  <= '0;
            r_final <= 1'b0;
            r_dr    <= '0;
            r_dc    <= '0;
        end else begin
            r_state <= n_state;
            if (i_restart) begin
                r_col  <= '0;
                r_row  <= '0;
                r_rmod <= '0;
            end else if (accept) begin
                if (is_final) begin
                    r_col  <= '0;
                    r_row  <= '0;
                    r_rmod <= '0;
                end else if (r_col == i_wlast) begin
                    r_col  <= '0;
                    r_row  <= r_row + FH_W'(1);
                    r_rmod <= mod3_inc(r_rmod);
                end else begin
                    r_col <= r_col + COL_W'(1);
                end
            end

            if (accept) begin
                r_final <= is_final;
                r_dr    <= '0;
                r_dc    <= '0;
            end else if ((r_state == S_READ) && !last_tap) begin
                if (r_dc == 2'd2) begin
                    r_dc <= '0;
                    r_dr <= r_dr + 2'd1;
                end else begin
                    r_dc <= r_dc + 2'd1;
                end
            end else if (load && !last_res) begin
                r_dr <= '0;
                r_dc <= '0;
            end
        end
    end

    // Output position: one row and one pixel behind the input, then walked
    // forward pixel by pixel during the end-of-frame flush.
    always_ff @(posedge i_clk) begin
        if (accept && has_res) begin
            if (r_col != '0) begin
                r_ocol <= r_col - COL_W'(1);
                r_orow <= r_row - FH_W'(1);
                r_omod <= mod3_dec(r_rmod);
            end else begin
                r_ocol <= i_wlast;
                r_orow <= r_row - FH_W'(2);
                r_omod <= mod3_inc(r_rmod);
            end
        end else if (load && !last_res) begin
            if (r_ocol == i_wlast) begin
                r_ocol <= '0;
                r_orow <= r_orow + FH_W'(1);
                r_omod <= mod3_inc(r_omod);
            end else begin
                r_ocol <= r_ocol + COL_W'(1);
            end
        end
    end

endmodule

[design/bb3_mean.sv]
// Window accumulator, divide-by-nine by reciprocal multiply, and the output register.
// Depends on bb3_pkg; fed by the line store read data and the sequencer controls.
module bb3_mean #(
    parameter int PIXEL_BITS = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bb3_pkg::t_acc_ctl            i_acc,
    input  logic [PIXEL_BITS-1:0]        i_rd_data,
    input  logic                         i_m_tready,
    output logic                         o_m_tvalid,
    output logic [bb3_pkg::FIELD_W-1:0]  o_m_tdata,
    output logic                         o_m_tlast,
    output logic                         o_m_tuser,
    output logic                         o_out_free
);
    import bb3_pkg::*;

    localparam int SUM_W   = PIXEL_BITS + 4;
    localparam int SHIFT   = SUM_W + 4;
    localparam int RECIP_W = SHIFT - 3;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((1 << SHIFT) + 8) / 9);

    logic [SUM_W-1:0]            r_sum;
    logic [PROD_W-1:0]           prod;
    logic [PIXEL_BITS-1:0]       mean;
    logic [PIXEL_BITS+FIELD_W-1:0] mean_ext;
    logic                        r_valid, r_last, r_eof;
    logic [FIELD_W-1:0]          r_data;

    always_ff @(posedge i_clk) begin
        if (i_acc.clr) begin
            r_sum <= '0;
        end else if (i_acc.en) begin
            r_sum <= r_sum + SUM_W'(i_rd_data);
        end
    end

    // The reciprocal is exact for every sum of nine pixels.
    assign prod     = PROD_W'(r_sum) * PROD_W'(RECIP);
    assign mean     = i_acc.interior ? prod[SHIFT +: PIXEL_BITS] : r_sum[PIXEL_BITS-1:0];
    assign mean_ext = {{FIELD_W{1'b0}}, mean};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_acc.load) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc.load) begin
            r_data <= mean_ext[FIELD_W-1:0];
            r_last <= i_acc.last;
            r_eof  <= i_acc.eof;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_data;
    assign o_m_tlast  = r_last;
    assign o_m_tuser  = r_eof;
    assign o_out_free = !r_valid || i_m_tready;

endmodule

[design/box_blur_3x3_stream_core.sv]
// 3x3 box blur over a raster pixel stream; needs bb3_pkg, bb3_cfg, bb3_ctrl,
// bb3_line_store, bb3_mean and assert_macros.svh.
// A pixel beat that releases an interior result reads its full 3x3 window, a border one only the center.
// Throughput is set by the single read port: no new pixel is taken until the sequencer is idle again,
// and the final pixel flushes up to MAX_WIDTH+1 more results.
// Reset (synchronous, active low) restarts the frame and sets width and height to 5.
`include "assert_macros.svh"

module box_blur_3x3_stream_core #(
    parameter int MAX_WIDTH  = 32,
    parameter int PIXEL_BITS = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Slave stream: one original pixel per beat.
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [bb3_pkg::FIELD_W-1:0]        i_s_axis_tdata,   // [7:0] pixel_in
    // Master stream: one result pixel per beat.
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    output logic [bb3_pkg::FIELD_W-1:0]        o_m_axis_tdata,   // [7:0] pixel_out
    output logic                               o_m_axis_tlast,   // last_of_run
    output logic                               o_m_axis_tuser,   // [0] end_of_frame
    // Configuration: frame_width at 0x0, frame_height at 0x4.
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [bb3_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [bb3_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [bb3_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);
    import bb3_pkg::*;

    localparam int DEPTH  = 3 * MAX_WIDTH;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int COL_W  = $clog2(MAX_WIDTH);

    // The line store keeps the three most recent rows of original pixels, row r
    // in the bank r mod 3. Each pixel beat writes its own entry, after which the
    // sequencer reads back the 3x3 window of the pending result one entry per
    // cycle (or just the center entry on the frame border). Writes and reads
    // never fall in the same cycle, so no forwarding is needed: the sequencer
    // itself is the interlock.

    logic [COL_W-1:0]      wlast;
    logic [FH_W-1:0]       hlast;
    logic                  restart;
    logic                  out_free;
    logic                  wr_en, rd_en;
    logic [ADDR_W-1:0]     wr_addr, rd_addr;
    logic [PIXEL_BITS-1:0] rd_data;
    logic [PIXEL_BITS-1:0] pixel;
    logic [PIXEL_BITS+FIELD_W-1:0] pixel_ext;
    t_acc_ctl              acc_ctl;

    // Only the low PIXEL_BITS of the input field are kept.
    assign pixel_ext = {{PIXEL_BITS{1'b0}}, i_s_axis_tdata};
    assign pixel     = pixel_ext[PIXEL_BITS-1:0];

    bb3_cfg #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_wlast   (wlast),
        .o_hlast   (hlast),
        .o_restart (restart)
    );

    bb3_ctrl #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_valid  (i_s_axis_tvalid),
        .o_s_ready  (o_s_axis_tready),
        .i_wlast    (wlast),
        .i_hlast    (hlast),
        .i_restart  (restart),
        .i_out_free (out_free),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .o_acc      (acc_ctl)
    );

    bb3_line_store #(
        .DEPTH (DEPTH),
        .DATA_W(PIXEL_BITS)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (pixel),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // The output register lets the sequencer return to idle and take the next
    // pixel while the last result of a run still waits on the master side.
    bb3_mean #(
        .PIXEL_BITS(PIXEL_BITS)
    ) u_mean (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_acc      (acc_ctl),
        .i_rd_data  (rd_data),
        .i_m_tready (i_m_axis_tready),
        .o_m_tvalid (o_m_axis_tvalid),
        .o_m_tdata  (o_m_axis_tdata),
        .o_m_tlast  (o_m_axis_tlast),
        .o_m_tuser  (o_m_axis_tuser),
        .o_out_free (out_free)
    );

    // The end-of-frame result always closes its run.
    `BB3_ASSERT_NOW(a_eof_last, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser, o_m_axis_tlast)
    // A new result is only loaded when the output register is free.
    `BB3_ASSERT_NOW(a_load_free, i_clk, i_rst_n, acc_ctl.load, !o_m_axis_tvalid || i_m_axis_tready)
    // While a flush is still running, no new pixel is taken.
    `BB3_ASSERT_NEXT(a_flush_hold, i_clk, i_rst_n, acc_ctl.load && !acc_ctl.last, !o_s_axis_tready)

endmodule

[verif/tb.sv]
// Self-checking testbench for the 3x3 box blur stream core.
// Depends on bb3_pkg and box_blur_3x3_stream_core; needs no files or arguments.
module tb;
    import bb3_pkg::*;

    localparam int MAX_W        = 32;
    localparam int STORE_DEPTH  = 3 * MAX_W;
    // Settling margin for a pixel still in flight after the last expected beat.
    localparam int SETTLE_CYCLES = 16;
    localparam int ITEM_TARGET   = 410;

    // One expected beat on the master stream.
    typedef struct packed {
        logic [FIELD_W-1:0] pixel;
        logic               last;
        logic               eof;
    } t_blur_result;

    // Every input of the core starts from a known value.
    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic [FIELD_W-1:0]    i_s_axis_tdata  = '0;
    logic                  i_m_axis_tready = 1'b0;
    logic                  psel            = 1'b0;
    logic                  penable         = 1'b0;
    logic                  pwrite          = 1'b0;
    logic [APB_ADDR_W-1:0] paddr           = '0;
    logic [APB_DATA_W-1:0] pwdata          = '0;

    logic                  o_s_axis_tready;
    logic                  o_m_axis_tvalid;
    logic [FIELD_W-1:0]    o_m_axis_tdata;
    logic                  o_m_axis_tlast;
    logic                  o_m_axis_tuser;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Percent chance that the sender or the receiver idles in a given cycle.
    int send_idle_pct = 27;
    int recv_idle_pct = 77;

    int error_count     = 0;
    int pixels_sent     = 0;
    int results_checked = 0;
    int frames_closed   = 0;

    // Our own copy of the core's state: three original rows, the raster
    // position of the next pixel and the two frame size registers.
    logic [FIELD_W-1:0] line_mem [STORE_DEPTH];
    logic [FW_W-1:0]    width_reg  = FW_RESET;
    logic [FH_W-1:0]    height_reg = FH_RESET;
    int unsigned        col_pos    = 0;
    int unsigned        row_pos    = 0;
    t_blur_result       expected_q[$];

    always #10 i_clk = ~i_clk;

    box_blur_3x3_stream_core #(
        .MAX_WIDTH  (MAX_W),
        .PIXEL_BITS (FIELD_W)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),   // [7:0] pixel_in
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),   // [7:0] pixel_out
        .o_m_axis_tlast  (o_m_axis_tlast),   // last_of_run
        .o_m_axis_tuser  (o_m_axis_tuser),   // [0] end_of_frame
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // The width register is clamped into 3..MAX_W, the height only from below.
    function automatic int unsigned active_width();
        if (width_reg < 3) return 3;
        if (width_reg > MAX_W) return MAX_W;
        return width_reg;
    endfunction

    function automatic int unsigned active_height();
        return (height_reg < 3) ? 3 : height_reg;
    endfunction

    // Rows rotate through the three line stores by row number modulo three.
    function automatic logic [FIELD_W-1:0] stored_pixel(int unsigned r, int unsigned c);
        return line_mem[(r % 3) * MAX_W + c];
    endfunction

    // Border pixels pass through; interior ones become the truncated 3x3 mean.
    function automatic logic [FIELD_W-1:0] blurred_pixel(int unsigned r, int unsigned c,
                                                         int unsigned w, int unsigned h);
        int unsigned sum;
        int unsigned dr;
        int unsigned dc;
        sum = 0;
        if (r < 1 || r > h - 2 || c < 1 || c > w - 2) return stored_pixel(r, c);
        for (dr = 0; dr < 3; dr++) begin
            for (dc = 0; dc < 3; dc++) begin
                sum += stored_pixel(r - 1 + dr, c - 1 + dc);
            end
        end
        return FIELD_W'(sum / 9);
    endfunction

    // Stores an accepted pixel and queues every result it releases. Output
    // trails the input by one row plus one pixel; the final pixel of a frame
    // flushes the rest of the frame, and only the last of those carries
    // tlast together with the end-of-frame flag.
    function automatic void predict_pixel(logic [FIELD_W-1:0] pix);
        int unsigned  w;
        int unsigned  h;
        int unsigned  ri;
        int unsigned  ci;
        int unsigned  orow;
        int unsigned  ocol;
        logic         frame_done;
        logic         eof;
        logic         last;
        t_blur_result res;
        w  = active_width();
        h  = active_height();
        ri = (row_pos > h - 1) ? h - 1 : row_pos;
        ci = (col_pos > w - 1) ? w - 1 : col_pos;
        line_mem[(ri % 3) * MAX_W + ci] = pix;
        frame_done = (ri == h - 1) && (ci == w - 1);
        if (ri >= 2 || (ri == 1 && ci >= 1)) begin
            if (ci >= 1) begin
                orow = ri - 1;
                ocol = ci - 1;
            end else begin
                orow = ri - 2;
                ocol = w - 1;
            end
            last = 1'b0;
            while (!last) begin
                eof       = frame_done && orow == h - 1 && ocol == w - 1;
                last      = !frame_done || eof;
                res.pixel = blurred_pixel(orow, ocol, w, h);
                res.last  = last;
                res.eof   = eof;
                expected_q.push_back(res);
                if (ocol + 1 >= w) begin
                    ocol = 0;
                    orow++;
                end else begin
                    ocol++;
                end
            end
        end
        if (frame_done) begin
            col_pos = 0;
            row_pos = 0;
        end else if (ci + 1 >= w) begin
            col_pos = 0;
            row_pos = (ri + 1) & 12'hFFF;
        end else begin
            col_pos = ci + 1;
            row_pos = ri;
        end
    endfunction

    // Result side: randomly stalls the master stream and checks every beat
    // taken against the oldest prediction. Values are sampled at the edge
    // before any nonblocking update of that edge lands.
    always @(posedge i_clk) begin
        t_blur_result want;
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_q.size() == 0) begin
                    $error("result beat with nothing expected: pixel_out %0d", o_m_axis_tdata);
                    error_count++;
                end else begin
                    want = expected_q.pop_front();
                    results_checked++;
                    if (o_m_axis_tdata !== want.pixel) begin
                        $error("pixel_out: expected %0d, got %0d", want.pixel, o_m_axis_tdata);
                        error_count++;
                    end
                    if (o_m_axis_tlast !== want.last) begin
                        $error("last_of_run: expected %0b, got %0b", want.last, o_m_axis_tlast);
                        error_count++;
                    end
                    if (o_m_axis_tuser !== want.eof) begin
                        $error("end_of_frame: expected %0b, got %0b", want.eof, o_m_axis_tuser);
                        error_count++;
                    end
                    if (want.eof) frames_closed++;
                end
            end
            i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Sends one pixel beat, with random idle cycles in front of it. The valid
    // is left high after the beat, so the next call can keep it up without a
    // second assignment in the same step.
    task automatic send_pixel(input logic [FIELD_W-1:0] pix);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= pix;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_pixel(pix);
        pixels_sent++;
    endtask

    // Stops the sender and waits until every predicted beat has arrived,
    // then lets extra cycles pass for a pixel that releases no result.
    task automatic settle_block(input int extra_cycles);
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_q.size() != 0);
        repeat (extra_cycles) @(posedge i_clk);
    endtask

    // Register write: setup cycle, then access cycle until pready. A write
    // also restarts the frame in the core, so the position returns to zero.
    task automatic write_frame_reg(input logic reg_idx, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        if (reg_idx == REG_FRAME_WIDTH) width_reg = value[FW_W-1:0];
        else                            height_reg = value[FH_W-1:0];
        col_pos = 0;
        row_pos = 0;
    endtask

    task automatic set_frame_size(input int unsigned w, input int unsigned h);
        settle_block(SETTLE_CYCLES);
        write_frame_reg(REG_FRAME_WIDTH, w);
        write_frame_reg(REG_FRAME_HEIGHT, h);
    endtask

    // Random pixel, leaning on black and white so that full-scale sums occur.
    function automatic logic [FIELD_W-1:0] random_pixel();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return FIELD_W'($urandom_range(255));
        endcase
    endfunction

    task automatic send_random_pixels(input int unsigned count);
        repeat (count) send_pixel(random_pixel());
    endtask

    // Whole 5x5 frame at the reset size. The top-left corner is all white,
    // so its first interior mean is 255, the corner at the bottom right is
    // mostly black, and the bottom rows walk single bits through the pixel.
    // Halfway through, the sender waits for the core to empty completely.
    task automatic test_reset_size_frame();
        logic [FIELD_W-1:0] image [25];
        int i;
        image = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
                  8'd255, 8'd255, 8'd255, 8'd255, 8'd0,
                  8'd255, 8'd255, 8'd255, 8'd0,   8'd0,
                  8'd0,   8'd0,   8'd1,   8'd128, 8'd0,
                  8'd0,   8'd127, 8'd64,  8'd2,   8'd255};
        for (i = 0; i < 25; i++) begin
            if (i == 12) settle_block(0);
            send_pixel(image[i]);
        end
    endtask

    // Sizes outside the useful range are clamped: all-zero and small values
    // give a 3x3 frame, an all-ones width gives the widest frame, whose final
    // pixel flushes a full row plus one.
    task automatic test_clamped_sizes();
        set_frame_size(0, 0);
        send_random_pixels(active_width() * active_height());
        set_frame_size(2, 1);
        send_random_pixels(active_width() * active_height());
        set_frame_size(63, 2);
        send_random_pixels(active_width() * active_height());
    endtask

    // The tallest frame is far too long to finish, so a few rows are sent and
    // the frame is then abandoned by the next register write.
    task automatic test_tall_frame_abandoned();
        set_frame_size(3, 12'hFFF);
        send_random_pixels(3 * 3 + 2);
    endtask

    // Random frames until the pixel count reaches the goal. Most are small
    // and complete; a few are the widest, out of range or cut short, and some
    // follow on without a register write to check the return to row zero.
    task automatic test_random_frames(input int goal, input int send_pct, input int recv_pct);
        int unsigned w;
        int unsigned h;
        int unsigned frame_pixels;
        bit          first;
        first         = 1'b1;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        while (pixels_sent < goal) begin
            if (first || $urandom_range(3) != 0) begin
                case ($urandom_range(19))
                    0: begin
                        w = $urandom_range(2);
                        h = $urandom_range(2);
                    end
                    1: begin
                        w = $urandom_range(63, 33);
                        h = 3;
                    end
                    2: begin
                        w = MAX_W;
                        h = $urandom_range(4, 3);
                    end
                    default: begin
                        w = $urandom_range(8, 3);
                        h = $urandom_range(5, 3);
                    end
                endcase
                if (active_width() * active_height() > 200 && w == MAX_W) h = 3;
                set_frame_size(w, h);
            end
            first        = 1'b0;
            frame_pixels = active_width() * active_height() - row_pos * active_width() - col_pos;
            if ($urandom_range(7) == 0) frame_pixels = $urandom_range(frame_pixels - 1, 1);
            send_random_pixels(frame_pixels);
        end
    endtask

    initial begin
        int base;
        int chunk;
        foreach (line_mem[i]) line_mem[i] = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_size_frame();
        test_clamped_sizes();
        test_tall_frame_abandoned();

        // Three idling phases: receiver sparse, then sender sparse, then none.
        base  = pixels_sent;
        chunk = (ITEM_TARGET - base) / 3;
        test_random_frames(base + chunk, 27, 77);
        test_random_frames(base + 2 * chunk, 77, 27);
        test_random_frames(ITEM_TARGET, 0, 0);

        settle_block(4 * SETTLE_CYCLES);

        $display("summary: %0d pixel beats in, %0d result beats checked, %0d frames closed",
                 pixels_sent, results_checked, frames_closed);
        $display("summary: clamped, widest, tallest, abandoned and back-to-back frames run");
        if (error_count == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    // Guard against a hung handshake: far longer than the slowest legal run.
    initial begin
        #20000000;
        $display("tb: errors");
        $finish;
    end

endmodule

[sim.f]
+incdir+design
design/bb3_pkg.sv
design/bb3_line_store.sv
design/bb3_cfg.sv
design/bb3_ctrl.sv
design/bb3_mean.sv
design/box_blur_3x3_stream_core.sv
verif/tb.sv
